### rtl/motion_to_photon_latency_meter_macros.svh
// assertion helpers used by the checker file
`ifndef MOTION_TO_PHOTON_LATENCY_METER_MACROS_SVH
`define MOTION_TO_PHOTON_LATENCY_METER_MACROS_SVH

// antecedent in one cycle, consequent in the next
`define MTP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle rule");

// antecedent and consequent in the same cycle
`define MTP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle rule");

`endif

### rtl/mtp_pkg.sv
// ----------------------------------------------------------------------------
// mtp_pkg
// Types, codes and helpers for the motion-to-photon latency meter.
// ----------------------------------------------------------------------------
package mtp_pkg;

   localparam int RATE_BITS    = 16;
   localparam int LIGHT_BITS   = 10;
   localparam int CSR_IDX_BITS = 3;
   localparam int DIR_W        = ((RATE_BITS > 16) ? RATE_BITS : 16) + 2;
   localparam int LDW          = ((LIGHT_BITS > 10) ? LIGHT_BITS : 10) + 2;
   localparam int SUM_W        = 48;
   localparam int CNT_W        = 16;

   localparam logic [2:0] EV_LATENCY  = 3'd0;
   localparam logic [2:0] EV_CALIB    = 3'd1;
   localparam logic [2:0] EV_RETRY    = 3'd2;
   localparam logic [2:0] EV_REPORT   = 3'd3;
   localparam logic [2:0] EV_INVERTED = 3'd4;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MOTION_LEVEL = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FAST_LEVEL   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CALIB_RANGE  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BRIGHT_STEP  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BRIGHT_RANGE = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CALM_TIMEOUT = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CALIB_WINDOW = 3'd6;

   localparam logic [1:0] AXIS_NONE = 2'd3;

   typedef enum logic [1:0] {
      PH_CALM      = 2'd0,
      PH_CALIB     = 2'd1,
      PH_REVDIR    = 2'd2,
      PH_REVBRIGHT = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   typedef struct packed {
      logic [31:0]                  stamp_us;
      logic signed [RATE_BITS-1:0]  rate_x;
      logic signed [RATE_BITS-1:0]  rate_y;
      logic signed [RATE_BITS-1:0]  rate_z;
      logic [LIGHT_BITS-1:0]        light_level;
   } req_type;

   typedef struct packed {
      logic [2:0]            event_kind;
      logic [31:0]           latency_us;
      logic [31:0]           min_us;
      logic [31:0]           max_us;
      logic [31:0]           mean_us;
      logic [15:0]           sample_count;
      logic [1:0]            axis_chosen;
      logic [RATE_BITS-1:0]  gyro_span;
      logic [LIGHT_BITS-1:0] light_span;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic div_start;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic has_result;
      logic need_div;
      logic div_done;
   } sts_type;

   // direction of a rate, integer part compared against the level
   function automatic dir_type rate_dir(input logic signed [RATE_BITS-1:0] r,
                                        input logic [14:0] lv);
      logic signed [DIR_W-1:0] ipw;
      logic signed [DIR_W-1:0] lvs;
      ipw = DIR_W'(r);
      ipw = {ipw[DIR_W-1:8], 8'b0};
      if (r[RATE_BITS-1] && (r[7:0] != 8'd0)) begin
         ipw = ipw + DIR_W'(256);
      end
      lvs = signed'(DIR_W'(lv));
      if (ipw >= lvs) begin
         return DIR_UP;
      end else if (ipw <= -lvs) begin
         return DIR_DOWN;
      end
      return DIR_NONE;
   endfunction

endpackage

### rtl/mtp_div.sv
// ----------------------------------------------------------------------------
// mtp_div
// Restoring divider, one quotient bit per cycle, for the report mean.
// ----------------------------------------------------------------------------
module mtp_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [mtp_pkg::SUM_W-1:0]  num,
   input  logic [mtp_pkg::CNT_W-1:0]  den,
   output logic                       done,
   output logic [31:0]                quotient
);
   localparam int NUM_W = mtp_pkg::SUM_W;
   localparam int DEN_W = mtp_pkg::CNT_W;
   localparam int STEP_W = $clog2(NUM_W);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W:0]    shifted;

   assign shifted  = {rem_ff, quo_ff[NUM_W-1]};
   assign done     = busy_ff && (cnt_ff == STEP_W'(NUM_W - 1));
   assign quotient = quo_ff[31:0];

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(shifted - {1'b0, den_ff});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + STEP_W'(1);
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

endmodule

### rtl/mtp_ctrl.sv
// ----------------------------------------------------------------------------
// mtp_ctrl
// Sequencer: accept, evaluate, optional mean division, publish.
// ----------------------------------------------------------------------------
module mtp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  mtp_pkg::sts_type  sts,
   output mtp_pkg::cmd_type  cmd
);
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EVAL = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_PUB  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      can_pub;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign can_pub   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      cmd           = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval      = 1'b1;
            cmd.div_start = sts.need_div;
            if (!sts.has_result) begin
               state_in = ST_IDLE;
            end else if (sts.need_div) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_PUB;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_PUB;
            end
         end
         ST_PUB: begin
            if (can_pub) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/mtp_datapath.sv
// ----------------------------------------------------------------------------
// mtp_datapath
// Sample register, phase state, statistics, settings and result registers.
// ----------------------------------------------------------------------------
module mtp_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  mtp_pkg::cmd_type                    cmd,
   output mtp_pkg::sts_type                    sts,
   input  mtp_pkg::req_type                    req_data,
   output mtp_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [mtp_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [31:0]                         csr_data
);
   localparam int RB  = mtp_pkg::RATE_BITS;
   localparam int LB  = mtp_pkg::LIGHT_BITS;
   localparam int DW  = mtp_pkg::DIR_W;
   localparam int LW  = mtp_pkg::LDW;

   // settings
   logic [14:0] motion_lvl_ff, fast_lvl_ff;
   logic [15:0] calib_range_ff;
   logic [9:0]  bright_step_ff, bright_range_ff;
   logic [31:0] calm_timeout_ff, calib_window_ff;

   // sample and results
   mtp_pkg::req_type smp_ff, smp_in;
   mtp_pkg::rsp_type res_ff, res_in, rsp_ff, rsp_in;
   logic             div_used_ff, div_used_in;

   // phase state
   logic                  primed_ff, primed_in;
   mtp_pkg::phase_type    phase_ff, phase_in;
   logic [31:0]           calm_since_ff, calm_since_in, calib_since_ff, calib_since_in;
   logic                  calib_first_ff, calib_first_in;
   logic [1:0]            track_ff, track_in;
   logic signed [RB-1:0]  axis_low_ff [3];
   logic signed [RB-1:0]  axis_low_in [3];
   logic signed [RB-1:0]  axis_high_ff [3];
   logic signed [RB-1:0]  axis_high_in [3];
   logic [LB-1:0]         light_low_ff, light_low_in, light_high_ff, light_high_in;
   logic                  moved_fast_ff, moved_fast_in;
   logic signed [RB-1:0]  prev_ff, prev_in;
   logic [31:0]           settle_time_ff, settle_time_in;
   logic [LB-1:0]         ref_light_ff, ref_light_in;
   mtp_pkg::dir_type      step_dir_ff, step_dir_in;
   logic [31:0]           step_time_ff, step_time_in;
   logic [15:0]           lat_count_ff, lat_count_in;
   logic [47:0]           lat_sum_ff, lat_sum_in;
   logic [31:0]           lat_min_ff, lat_min_in, lat_max_ff, lat_max_in;

   // evaluation intermediates
   logic signed [RB-1:0]  rate [3];
   logic [31:0]           now, cs, cb, lat;
   logic [LB-1:0]         light, lspan;
   logic                  moving, timeout, has_res, fast, settle, rev;
   mtp_pkg::phase_type    ph;
   logic                  cf;
   logic [1:0]            tr, best;
   logic signed [DW-1:0]  span [3];
   logic signed [DW-1:0]  best_span, vw, fw;
   logic signed [RB-1:0]  v;
   logic signed [LW-1:0]  dl, stw;
   mtp_pkg::dir_type      ch;
   mtp_pkg::rsp_type      res_new;

   logic        div_done;
   logic [31:0] div_q;

   mtp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .num      (lat_sum_ff),
      .den      (lat_count_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rate[0] = smp_ff.rate_x;
   assign rate[1] = smp_ff.rate_y;
   assign rate[2] = smp_ff.rate_z;
   assign now     = smp_ff.stamp_us;
   assign light   = smp_ff.light_level;
   assign cs      = primed_ff ? calm_since_ff : now;
   assign cb      = primed_ff ? calib_since_ff : now;
   assign moving  = (mtp_pkg::rate_dir(rate[0], motion_lvl_ff) != mtp_pkg::DIR_NONE) ||
                    (mtp_pkg::rate_dir(rate[1], motion_lvl_ff) != mtp_pkg::DIR_NONE) ||
                    (mtp_pkg::rate_dir(rate[2], motion_lvl_ff) != mtp_pkg::DIR_NONE);
   assign timeout = !moving && ((now - cs) >= calm_timeout_ff);

   assign sts.has_result = has_res;
   assign sts.need_div   = timeout && (lat_count_ff != 16'd0);
   assign sts.div_done   = div_done;
   assign rsp_data       = rsp_ff;

   always_comb begin
      res_new        = '0;
      has_res        = 1'b0;
      ph             = phase_ff;
      cf             = calib_first_ff;
      tr             = track_ff;
      calm_since_in  = cs;
      calib_since_in = cb;
      lat_count_in   = lat_count_ff;
      lat_sum_in     = lat_sum_ff;
      lat_min_in     = lat_min_ff;
      lat_max_in     = lat_max_ff;
      for (int i = 0; i < 3; i++) begin
         axis_low_in[i]  = axis_low_ff[i];
         axis_high_in[i] = axis_high_ff[i];
         span[i]         = '0;
      end
      light_low_in   = light_low_ff;
      light_high_in  = light_high_ff;
      moved_fast_in  = moved_fast_ff;
      prev_in        = prev_ff;
      settle_time_in = settle_time_ff;
      ref_light_in   = ref_light_ff;
      step_dir_in    = step_dir_ff;
      step_time_in   = step_time_ff;
      best           = 2'd0;
      best_span      = '0;
      lspan          = '0;
      v              = '0;
      vw             = '0;
      fw             = '0;
      fast           = 1'b0;
      settle         = 1'b0;
      dl             = '0;
      stw            = '0;
      ch             = mtp_pkg::DIR_NONE;
      rev            = 1'b0;
      lat            = step_time_ff - settle_time_ff;

      if (moving) begin
         calm_since_in = now;
      end else if (timeout) begin
         res_new.event_kind   = mtp_pkg::EV_REPORT;
         res_new.min_us       = lat_min_ff;
         res_new.max_us       = lat_max_ff;
         res_new.sample_count = lat_count_ff;
         has_res        = 1'b1;
         lat_count_in   = '0;
         lat_sum_in     = '0;
         lat_max_in     = '0;
         lat_min_in     = calm_timeout_ff;
         calm_since_in  = now;
         calib_since_in = now;
         tr             = mtp_pkg::AXIS_NONE;
         ph             = mtp_pkg::PH_CALIB;
         cf             = 1'b1;
      end
      calib_first_in = cf;

      case (ph)
         mtp_pkg::PH_CALIB: begin
            calib_first_in = 1'b0;
            for (int i = 0; i < 3; i++) begin
               if (cf) begin
                  axis_low_in[i]  = rate[i];
                  axis_high_in[i] = rate[i];
               end
               if (rate[i] < axis_low_in[i]) axis_low_in[i] = rate[i];
               if (rate[i] > axis_high_in[i]) axis_high_in[i] = rate[i];
               span[i] = DW'(axis_high_in[i]) - DW'(axis_low_in[i]);
            end
            if (cf) begin
               light_low_in  = light;
               light_high_in = light;
            end
            if (light < light_low_in) light_low_in = light;
            if (light > light_high_in) light_high_in = light;
            lspan     = light_high_in - light_low_in;
            best_span = span[0];
            if (span[1] > best_span) begin
               best_span = span[1];
               best      = 2'd1;
            end
            if (span[2] > best_span) begin
               best_span = span[2];
               best      = 2'd2;
            end
            if (!timeout && (tr == mtp_pkg::AXIS_NONE) && ((now - cb) >= calib_window_ff)) begin
               has_res             = 1'b1;
               res_new.axis_chosen = best;
               res_new.gyro_span   = best_span[RB-1:0];
               res_new.light_span  = lspan;
               if ((best_span < signed'(DW'(calib_range_ff))) ||
                   (LW'(lspan) < LW'(bright_range_ff))) begin
                  res_new.event_kind = mtp_pkg::EV_RETRY;
                  calib_since_in     = now;
                  calib_first_in     = 1'b1;
               end else begin
                  res_new.event_kind = mtp_pkg::EV_CALIB;
                  tr                 = best;
                  ph                 = mtp_pkg::PH_REVDIR;
               end
            end
         end
         mtp_pkg::PH_REVDIR: begin
            if (tr != mtp_pkg::AXIS_NONE) begin
               v    = rate[tr];
               vw   = DW'(v);
               fw   = signed'(DW'(fast_lvl_ff));
               fast = moved_fast_ff || (vw > fw) || (vw < -fw);
               settle = fast && (mtp_pkg::rate_dir(v, motion_lvl_ff) == mtp_pkg::DIR_NONE) &&
                        (mtp_pkg::rate_dir(prev_ff, motion_lvl_ff) != mtp_pkg::DIR_NONE);
               moved_fast_in = fast;
               prev_in       = v;
            end else begin
               prev_in = '0;
            end
            if (settle) begin
               settle_time_in = now;
               moved_fast_in  = 1'b0;
               prev_in        = '0;
               step_dir_in    = mtp_pkg::DIR_NONE;
               ph             = mtp_pkg::PH_REVBRIGHT;
            end
         end
         mtp_pkg::PH_REVBRIGHT: begin
            dl  = signed'(LW'(light)) - signed'(LW'(ref_light_ff));
            stw = signed'(LW'(bright_step_ff));
            if (dl >= stw) begin
               ch = mtp_pkg::DIR_UP;
            end else if (dl <= -stw) begin
               ch = mtp_pkg::DIR_DOWN;
            end
            if (ch != mtp_pkg::DIR_NONE) begin
               rev = ((ch == mtp_pkg::DIR_UP) && (step_dir_ff == mtp_pkg::DIR_DOWN)) ||
                     ((ch == mtp_pkg::DIR_DOWN) && (step_dir_ff == mtp_pkg::DIR_UP));
               ref_light_in = light;
               step_dir_in  = ch;
               step_time_in = now;
            end
            if (rev) begin
               has_res = 1'b1;
               if ((lat == 32'd0) || lat[31]) begin
                  res_new.event_kind = mtp_pkg::EV_INVERTED;
                  ph                 = mtp_pkg::PH_CALM;
               end else begin
                  res_new.event_kind = mtp_pkg::EV_LATENCY;
                  res_new.latency_us = lat;
                  if (lat_count_ff != 16'hFFFF) begin
                     lat_count_in = lat_count_ff + 16'd1;
                     lat_sum_in   = lat_sum_ff + 48'(lat);
                  end
                  if (lat < lat_min_ff) lat_min_in = lat;
                  if (lat > lat_max_ff) lat_max_in = lat;
                  ph = mtp_pkg::PH_REVDIR;
               end
            end
         end
         default: begin
         end
      endcase
      phase_in = ph;
      track_in = tr;
   end

   always_comb begin
      smp_in      = smp_ff;
      res_in      = res_ff;
      div_used_in = div_used_ff;
      primed_in   = primed_ff;
      rsp_in      = rsp_ff;
      if (cmd.load) begin
         smp_in = req_data;
      end
      if (cmd.eval) begin
         res_in      = res_new;
         div_used_in = sts.need_div;
         primed_in   = 1'b1;
      end
      if (cmd.publish) begin
         rsp_in = res_ff;
         if (div_used_ff) begin
            rsp_in.mean_us = div_q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motion_lvl_ff   <= 15'd256;
         fast_lvl_ff     <= 15'd192;
         calib_range_ff  <= 16'd1024;
         bright_step_ff  <= 10'd5;
         bright_range_ff <= 10'd7;
         calm_timeout_ff <= 32'd2000000;
         calib_window_ff <= 32'd1000000;
         primed_ff       <= 1'b0;
         phase_ff        <= mtp_pkg::PH_CALM;
         calm_since_ff   <= '0;
         calib_since_ff  <= '0;
         calib_first_ff  <= 1'b0;
         track_ff        <= mtp_pkg::AXIS_NONE;
         for (int i = 0; i < 3; i++) begin
            axis_low_ff[i]  <= '0;
            axis_high_ff[i] <= '0;
         end
         light_low_ff    <= '0;
         light_high_ff   <= '0;
         moved_fast_ff   <= 1'b0;
         prev_ff         <= '0;
         settle_time_ff  <= '0;
         ref_light_ff    <= '0;
         step_dir_ff     <= mtp_pkg::DIR_NONE;
         step_time_ff    <= '0;
         lat_count_ff    <= '0;
         lat_sum_ff      <= '0;
         lat_min_ff      <= 32'd2000000;
         lat_max_ff      <= '0;
         div_used_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               mtp_pkg::CSR_MOTION_LEVEL: motion_lvl_ff   <= csr_data[14:0];
               mtp_pkg::CSR_FAST_LEVEL:   fast_lvl_ff     <= csr_data[14:0];
               mtp_pkg::CSR_CALIB_RANGE:  calib_range_ff  <= csr_data[15:0];
               mtp_pkg::CSR_BRIGHT_STEP:  bright_step_ff  <= csr_data[9:0];
               mtp_pkg::CSR_BRIGHT_RANGE: bright_range_ff <= csr_data[9:0];
               mtp_pkg::CSR_CALM_TIMEOUT: calm_timeout_ff <= csr_data;
               mtp_pkg::CSR_CALIB_WINDOW: calib_window_ff <= csr_data;
               default: begin
               end
            endcase
         end
         primed_ff   <= primed_in;
         div_used_ff <= div_used_in;
         if (cmd.eval) begin
            phase_ff       <= phase_in;
            calm_since_ff  <= calm_since_in;
            calib_since_ff <= calib_since_in;
            calib_first_ff <= calib_first_in;
            track_ff       <= track_in;
            for (int i = 0; i < 3; i++) begin
               axis_low_ff[i]  <= axis_low_in[i];
               axis_high_ff[i] <= axis_high_in[i];
            end
            light_low_ff   <= light_low_in;
            light_high_ff  <= light_high_in;
            moved_fast_ff  <= moved_fast_in;
            prev_ff        <= prev_in;
            settle_time_ff <= settle_time_in;
            ref_light_ff   <= ref_light_in;
            step_dir_ff    <= step_dir_in;
            step_time_ff   <= step_time_in;
            lat_count_ff   <= lat_count_in;
            lat_sum_ff     <= lat_sum_in;
            lat_min_ff     <= lat_min_in;
            lat_max_ff     <= lat_max_in;
         end
      end
      smp_ff <= smp_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

endmodule

### rtl/motion_to_photon_latency_meter.sv
// ----------------------------------------------------------------------------
// motion_to_photon_latency_meter
// Measures head-motion to display-brightness latency from gyro and light
// samples; reports latency, calibration and statistics events.
// ----------------------------------------------------------------------------
// Usage:
//  req channel: one timestamped gyro + photosensor sample per transaction.
//  rsp channel: zero or one event per sample (latency, calibrated, retry,
//  statistics report, inverted error); unused fields read zero.
//  csr channel: register writes, always ready, issued while idle.
// Sequence:
//  a sample is accepted, then evaluated, and its event is registered into
//  the output register once that is free; the next sample is taken only
//  after the event is published. A sample that raises no event frees the
//  input once it has been evaluated. A statistics report with a nonzero count
//  runs the mean through a bit-serial divider, one quotient bit per cycle,
//  before the event is published.
// Reset: settings return to their defaults, phase calm, statistics cleared.
// Stall: an event waits in the output register while rsp_ready is low; the
//  next sample is still accepted and evaluated, and its event waits until
//  the register frees.
// ----------------------------------------------------------------------------
module motion_to_photon_latency_meter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  mtp_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output mtp_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mtp_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [31:0]                       csr_data
);
   mtp_pkg::cmd_type cmd;
   mtp_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   mtp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mtp_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule

### rtl/mtp_checker.sv
// ----------------------------------------------------------------------------
// mtp_checker
// Port-level checks on the latency meter, bound to the top level.
// ----------------------------------------------------------------------------
`include "motion_to_photon_latency_meter_macros.svh"

module mtp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mtp_pkg::rsp_type rsp_data
);
   // one sample in flight: no back-to-back accepts
   `MTP_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)
   `MTP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `MTP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))
   // only defined event codes leave the block
   `MTP_ASSERT_SAME(a_kind_legal, clock, reset, rsp_valid, rsp_data.event_kind <= mtp_pkg::EV_INVERTED)

endmodule

bind motion_to_photon_latency_meter mtp_checker u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### tb/motion_to_photon_latency_meter_test.sv
// ----------------------------------------------------------------------------
// motion_to_photon_latency_meter_test
// Self-checking bench for the latency meter. A directed table of samples is
// followed by random calibration and motion/brightness sequences, with random
// idling on both channels and several register settings. Every event is
// compared with a behavioral model of the phase machine.
// ----------------------------------------------------------------------------
module motion_to_photon_latency_meter_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   mtp_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   mtp_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [mtp_pkg::CSR_IDX_BITS-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   always #4 clock = ~clock;

   motion_to_photon_latency_meter dut (.*);

   // model settings
   logic [14:0] m_motion, m_fast;
   logic [15:0] m_crange;
   logic [9:0]  m_bstep, m_brange;
   logic [31:0] m_timeout, m_window;
   // model state
   bit                  m_primed, m_cfirst, m_fast_seen, m_settle_ok, m_rev_ok;
   mtp_pkg::phase_type  m_phase;
   logic [31:0]         m_calm_since, m_calib_since, m_settle_t, m_step_t, m_rev_t;
   logic [1:0]          m_axis;
   int                  m_lo[3], m_hi[3], m_prev, m_sdir;
   int                  m_llo, m_lhi, m_lref;
   logic [31:0]         m_cnt, m_min, m_max;
   logic [63:0]         m_sum;

   mtp_pkg::rsp_type expected_events[$];
   mtp_pkg::rsp_type last_ev;
   int pushed = 0;
   int mismatches = 0;
   int unexpected = 0;
   int rsp_gap = 0;
   logic [31:0] now_us = 32'd1000;

   function automatic int dir_of(int r);
      int ip;
      ip = (r / 256) * 256;
      if (ip >= int'(m_motion)) return 1;
      if (ip <= -int'(m_motion)) return -1;
      return 0;
   endfunction

   task automatic model_reset();
      m_motion = 256; m_fast = 192; m_crange = 1024; m_bstep = 5; m_brange = 7;
      m_timeout = 2000000; m_window = 1000000;
      m_primed = 0; m_phase = mtp_pkg::PH_CALM; m_cfirst = 0; m_axis = mtp_pkg::AXIS_NONE;
      m_lo = '{0, 0, 0}; m_hi = '{0, 0, 0}; m_llo = 0; m_lhi = 0;
      m_fast_seen = 0; m_prev = 0; m_settle_t = 0; m_settle_ok = 0; m_lref = 0;
      m_sdir = 0; m_step_t = 0; m_rev_t = 0; m_rev_ok = 0;
      m_cnt = 0; m_sum = 0; m_max = 0; m_min = m_timeout;
   endtask

   task automatic model_config(logic [mtp_pkg::CSR_IDX_BITS-1:0] idx, logic [31:0] v);
      case (idx)
         mtp_pkg::CSR_MOTION_LEVEL: m_motion = v[14:0];
         mtp_pkg::CSR_FAST_LEVEL:   m_fast = v[14:0];
         mtp_pkg::CSR_CALIB_RANGE:  m_crange = v[15:0];
         mtp_pkg::CSR_BRIGHT_STEP:  m_bstep = v[9:0];
         mtp_pkg::CSR_BRIGHT_RANGE: m_brange = v[9:0];
         mtp_pkg::CSR_CALM_TIMEOUT: m_timeout = v;
         mtp_pkg::CSR_CALIB_WINDOW: m_window = v;
         default: ;
      endcase
   endtask

   // advances the model by one sample; returns 1 with the event if one results
   function automatic bit predict_event(mtp_pkg::req_type s, output mtp_pkg::rsp_type ev);
      int r[3], lt, best, span, lspan, v, d, ch;
      bit moving, started, got;
      logic [31:0] lat;
      r[0] = $signed(s.rate_x); r[1] = $signed(s.rate_y); r[2] = $signed(s.rate_z);
      lt = s.light_level;
      ev = '0; got = 0; moving = 0; started = 0;
      if (!m_primed) begin
         m_primed = 1; m_calm_since = s.stamp_us; m_calib_since = s.stamp_us;
      end
      for (int i = 0; i < 3; i++) if (dir_of(r[i]) != 0) moving = 1;
      if (moving) begin
         m_calm_since = s.stamp_us;
      end else if (s.stamp_us - m_calm_since >= m_timeout) begin
         ev.event_kind = mtp_pkg::EV_REPORT;
         ev.min_us = m_min; ev.max_us = m_max;
         ev.mean_us = (m_cnt != 0) ? 32'(m_sum / m_cnt) : 32'd0;
         ev.sample_count = m_cnt[15:0];
         got = 1;
         m_cnt = 0; m_sum = 0; m_max = 0; m_min = m_timeout;
         m_calm_since = s.stamp_us; m_calib_since = s.stamp_us;
         m_axis = mtp_pkg::AXIS_NONE; m_phase = mtp_pkg::PH_CALIB; m_cfirst = 1;
         started = 1;
      end
      case (m_phase)
         mtp_pkg::PH_CALIB: begin
            if (m_cfirst) begin
               m_cfirst = 0;
               for (int i = 0; i < 3; i++) begin m_lo[i] = r[i]; m_hi[i] = r[i]; end
               m_llo = lt; m_lhi = lt;
            end
            for (int i = 0; i < 3; i++) begin
               if (r[i] < m_lo[i]) m_lo[i] = r[i];
               if (r[i] > m_hi[i]) m_hi[i] = r[i];
            end
            if (lt < m_llo) m_llo = lt;
            if (lt > m_lhi) m_lhi = lt;
            if (!started && m_axis == mtp_pkg::AXIS_NONE &&
                s.stamp_us - m_calib_since >= m_window) begin
               best = 0; span = m_hi[0] - m_lo[0]; lspan = m_lhi - m_llo;
               for (int i = 1; i < 3; i++)
                  if (m_hi[i] - m_lo[i] > span) begin span = m_hi[i] - m_lo[i]; best = i; end
               ev = '0;
               ev.axis_chosen = best[1:0]; ev.gyro_span = span[15:0];
               ev.light_span = lspan[9:0];
               got = 1;
               if (span < int'(m_crange) || lspan < int'(m_brange)) begin
                  ev.event_kind = mtp_pkg::EV_RETRY;
                  m_calib_since = s.stamp_us; m_cfirst = 1;
               end else begin
                  ev.event_kind = mtp_pkg::EV_CALIB;
                  m_axis = best[1:0]; m_settle_ok = 0; m_phase = mtp_pkg::PH_REVDIR;
               end
            end
         end
         mtp_pkg::PH_REVDIR: begin
            if (m_axis != mtp_pkg::AXIS_NONE) begin
               v = r[m_axis];
               if (v > int'(m_fast) || v < -int'(m_fast)) m_fast_seen = 1;
               if (m_fast_seen && dir_of(v) == 0 && dir_of(m_prev) != 0) begin
                  m_settle_t = s.stamp_us; m_settle_ok = 1;
               end
               m_prev = v;
            end else begin
               m_prev = 0;
            end
            if (m_settle_ok) begin
               m_fast_seen = 0; m_prev = 0; m_rev_ok = 0; m_sdir = 0;
               m_phase = mtp_pkg::PH_REVBRIGHT;
            end
         end
         mtp_pkg::PH_REVBRIGHT: begin
            d = lt - m_lref; ch = 0;
            if (d >= int'(m_bstep)) ch = 1;
            else if (d <= -int'(m_bstep)) ch = -1;
            if (ch != 0) begin
               if (ch * m_sdir == -1) begin m_rev_t = m_step_t; m_rev_ok = 1; end
               m_lref = lt; m_sdir = ch; m_step_t = s.stamp_us;
            end
            if (m_rev_ok) begin
               lat = m_rev_t - m_settle_t;
               ev = '0; got = 1;
               m_settle_ok = 0;
               if (lat == 0 || lat[31]) begin
                  ev.event_kind = mtp_pkg::EV_INVERTED;
                  m_rev_ok = 0; m_phase = mtp_pkg::PH_CALM;
               end else begin
                  ev.event_kind = mtp_pkg::EV_LATENCY; ev.latency_us = lat;
                  if (m_cnt < 32'hFFFF) begin m_cnt++; m_sum += lat; end
                  if (lat < m_min) m_min = lat;
                  if (lat > m_max) m_max = lat;
                  m_phase = mtp_pkg::PH_REVDIR;
               end
            end
         end
         default: ;
      endcase
      return got;
   endfunction

   // valid stays up after acceptance until the next call or a drain
   task automatic send_sample(mtp_pkg::req_type s);
      mtp_pkg::rsp_type ev;
      int idle;
      idle = $urandom_range(0, 16);
      if (idle != 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (predict_event(s, ev)) begin
         expected_events.push_back(ev);
         last_ev = ev;
         pushed++;
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(logic [mtp_pkg::CSR_IDX_BITS-1:0] idx, logic [31:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      model_config(idx, v);
   endtask

   // result side: random wait after each transaction, compare with oldest expectation
   always @(posedge clock) begin
      mtp_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               unexpected++;
               if (mismatches + unexpected <= 10)
                  $display("unexpected event %p", rsp_data);
            end else begin
               want = expected_events.pop_front();
               if (rsp_data !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p actual %p", want, rsp_data);
               end
            end
            rsp_gap = $urandom_range(0, 16);
            if (rsp_gap != 0) rsp_ready <= 1'b0;
         end else if (!rsp_ready) begin
            if (rsp_gap == 0) rsp_ready <= 1'b1;
            else rsp_gap--;
         end
      end
   end

   function automatic mtp_pkg::req_type mk(logic [31:0] t, int x, int y, int z, int l);
      mtp_pkg::req_type s;
      s.stamp_us = t; s.rate_x = x[15:0]; s.rate_y = y[15:0]; s.rate_z = z[15:0];
      s.light_level = l[9:0];
      return s;
   endfunction

   // one sample stepping time forward
   task automatic step(int dt, int x, int y, int z, int l);
      now_us += dt;
      send_sample(mk(now_us, x, y, z, l));
   endtask

   // calm, calibrate on a random axis, then several motion/brightness cycles
   task automatic measure_sequence(int cycles);
      int ax, amp, l0, lat;
      int rr[3];
      step(32'd2100, 0, 0, 0, 500);
      ax = $urandom_range(0, 2);
      for (int k = 0; k < 4; k++) begin
         rr = '{$urandom_range(0, 60) - 30, $urandom_range(0, 60) - 30,
                $urandom_range(0, 60) - 30};
         rr[ax] = (k % 2) ? 1200 : -1200;
         step(300, rr[0], rr[1], rr[2], 480 + 20 * k);
      end
      l0 = 540;
      for (int c = 0; c < cycles; c++) begin
         amp = $urandom_range(400, 3000) * (($urandom_range(0, 1)) ? 1 : -1);
         rr = '{0, 0, 0}; rr[ax] = amp;
         step($urandom_range(5, 40), rr[0], rr[1], rr[2], l0);
         step($urandom_range(5, 40), rr[0], rr[1], rr[2], l0);
         rr[ax] = $urandom_range(0, 1) ? 10 : -10;
         step($urandom_range(5, 40), rr[0], rr[1], rr[2], l0);
         lat = $urandom_range(1, 60);
         step(lat, 0, 0, 0, l0 + 40);
         step($urandom_range(1, 60), 0, 0, 0, l0);
         step($urandom_range(1, 30), 0, 0, 0, l0 + 3);
      end
   endtask

   task automatic noise(int n);
      mtp_pkg::req_type s;
      for (int k = 0; k < n; k++) begin
         s.stamp_us = $urandom;
         s.rate_x = 16'($urandom);
         s.rate_y = 16'($urandom);
         s.rate_z = 16'($urandom);
         s.light_level = 10'($urandom);
         if ($urandom_range(0, 1)) s.stamp_us = now_us + $urandom_range(0, 5000);
         now_us = s.stamp_us;
         send_sample(s);
      end
   endtask

   typedef struct {
      int dt, x, y, z, l;
      bit known;
      logic [2:0] kind;
   } row_type;

   row_type dir_rows[] = '{
      '{0, 0, 0, 0, 0, 0, 0},
      '{1, 32767, -32768, 0, 1023, 0, 0},
      '{2000000, 0, 0, 0, 0, 1, mtp_pkg::EV_REPORT},
      '{500000, 255, -255, 0, 0, 0, 0},
      '{500000, 2000, 0, -2000, 20, 0, 0},
      '{10, 0, 0, 0, 0, 0, 0},
      '{10, 3000, 0, 0, 0, 0, 0},
      '{10, 100, 0, 0, 0, 0, 0},
      '{10, 0, 0, 0, 50, 0, 0},
      '{10, 0, 0, 0, 0, 0, 0},
      '{10, 0, 0, 0, 900, 0, 0},
      '{10, -256, 0, 0, 900, 0, 0},
      '{10, -257, 0, 0, 900, 0, 0},
      '{10, 0, 0, 0, 0, 0, 0},
      '{2000000, 0, 0, 0, 0, 0, 0},
      '{1, 0, 0, 0, 0, 0, 0},
      '{2000000, 0, 0, 0, 0, 0, 0}
   };

   initial begin
      mtp_pkg::rsp_type ev;
      int pushed_before;
      model_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[i]) begin
         now_us += dir_rows[i].dt;
         ev = '0;
         if (dir_rows[i].known) begin
            ev.event_kind = dir_rows[i].kind;
            // statistics report from an empty set reads back the timeout as min
            if (dir_rows[i].kind == mtp_pkg::EV_REPORT) ev.min_us = m_timeout;
         end
         pushed_before = pushed;
         send_sample(mk(now_us, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                        dir_rows[i].l));
         if (dir_rows[i].known && (pushed == pushed_before || last_ev !== ev))
            begin
               mismatches++;
               if (mismatches <= 10)
                  $display("table row %0d: expected %p model %p", i, ev, last_ev);
            end
      end
      // pause the sender until every event is out
      wait_drained();
      for (int phase_no = 0; phase_no < 5; phase_no++) begin
         case (phase_no)
            0: begin
               write_reg(mtp_pkg::CSR_MOTION_LEVEL, 256);
               write_reg(mtp_pkg::CSR_FAST_LEVEL, 192);
               write_reg(mtp_pkg::CSR_CALIB_RANGE, 1024);
               write_reg(mtp_pkg::CSR_BRIGHT_STEP, 5);
               write_reg(mtp_pkg::CSR_BRIGHT_RANGE, 7);
               write_reg(mtp_pkg::CSR_CALM_TIMEOUT, 2000);
               write_reg(mtp_pkg::CSR_CALIB_WINDOW, 500);
            end
            1: begin
               write_reg(mtp_pkg::CSR_MOTION_LEVEL, 0);
               write_reg(mtp_pkg::CSR_FAST_LEVEL, 32767);
               write_reg(mtp_pkg::CSR_CALIB_RANGE, 0);
               write_reg(mtp_pkg::CSR_BRIGHT_STEP, 0);
               write_reg(mtp_pkg::CSR_BRIGHT_RANGE, 0);
               write_reg(mtp_pkg::CSR_CALIB_WINDOW, 0);
            end
            2: begin
               write_reg(mtp_pkg::CSR_MOTION_LEVEL, 32767);
               write_reg(mtp_pkg::CSR_FAST_LEVEL, 0);
               write_reg(mtp_pkg::CSR_CALIB_RANGE, 65535);
               write_reg(mtp_pkg::CSR_BRIGHT_STEP, 1023);
               write_reg(mtp_pkg::CSR_BRIGHT_RANGE, 1023);
               write_reg(mtp_pkg::CSR_CALM_TIMEOUT, 0);
               write_reg(mtp_pkg::CSR_CALIB_WINDOW, 32'hFFFF_FFFF);
            end
            3: begin
               write_reg(mtp_pkg::CSR_MOTION_LEVEL, 384);
               write_reg(mtp_pkg::CSR_FAST_LEVEL, 300);
               write_reg(mtp_pkg::CSR_CALIB_RANGE, 600);
               write_reg(mtp_pkg::CSR_BRIGHT_STEP, 8);
               write_reg(mtp_pkg::CSR_BRIGHT_RANGE, 10);
               write_reg(mtp_pkg::CSR_CALM_TIMEOUT, 32'hFFFF_FFFF);
               write_reg(mtp_pkg::CSR_CALIB_WINDOW, 800);
            end
            default: begin
               write_reg(mtp_pkg::CSR_MOTION_LEVEL, 256);
               write_reg(mtp_pkg::CSR_FAST_LEVEL, 192);
               write_reg(mtp_pkg::CSR_CALIB_RANGE, 1024);
               write_reg(mtp_pkg::CSR_BRIGHT_STEP, 5);
               write_reg(mtp_pkg::CSR_BRIGHT_RANGE, 7);
               write_reg(mtp_pkg::CSR_CALM_TIMEOUT, 2000);
               write_reg(mtp_pkg::CSR_CALIB_WINDOW, 500);
            end
         endcase
         csr_valid <= 1'b0;
         for (int k = 0; k < 6; k++) begin
            if (phase_no == 3 && k == 0) begin
               // huge timeout: only reach calm after a long quiet sample
               now_us += 32'hFFFF_FFF0;
            end
            measure_sequence($urandom_range(3, 8));
            noise($urandom_range(2, 8));
         end
         wait_drained();
      end
      $display("covered directed table, five register settings, calibration, latency,");
      $display("retry, report and inverted paths with random stalls on both channels");
      if (mismatches == 0 && unexpected == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule

### filelist.f
+incdir+rtl
rtl/mtp_pkg.sv
rtl/mtp_div.sv
rtl/mtp_ctrl.sv
rtl/mtp_datapath.sv
rtl/motion_to_photon_latency_meter.sv
rtl/mtp_checker.sv
tb/motion_to_photon_latency_meter_test.sv
